@@ rtl/lspan_pkg.sv @@
package lspan_pkg;

  localparam int unsigned ChannelCount = 8;
  localparam int unsigned ChanW        = $clog2(ChannelCount);
  localparam int unsigned CodeW        = 3;
  localparam int unsigned PosW         = ChannelCount * CodeW;
  localparam int unsigned PaddrW       = 3;
  localparam int unsigned PdataW       = 32;
  localparam int unsigned GainW        = 17;
  localparam int unsigned MagW         = 15;
  localparam int unsigned SampleW      = 16;

  // register indexes
  localparam logic RegPositions = 1'b0;
  localparam logic RegSwap      = 1'b1;

  typedef logic [ChanW-1:0]          chan_t;
  typedef logic [CodeW-1:0]          code_t;
  typedef logic [GainW-1:0]          gain_t;
  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic [PosW-1:0] stereo_positions;
    logic            swap_sides;
  } cfg_t;

  // chord base: (2^chord - 1) * 132
  function automatic logic [MagW-1:0] chord_base(input logic [2:0] chord);
    logic [MagW-1:0] b;
    case (chord)
      3'd0:    b = 15'd0;
      3'd1:    b = 15'd132;
      3'd2:    b = 15'd396;
      3'd3:    b = 15'd924;
      3'd4:    b = 15'd1980;
      3'd5:    b = 15'd4092;
      3'd6:    b = 15'd8316;
      default: b = 15'd16764;
    endcase
    return b;
  endfunction

  // chord step: floor(2^chord * 132 / 16)
  function automatic logic [10:0] chord_step(input logic [2:0] chord);
    logic [10:0] s;
    case (chord)
      3'd0:    s = 11'd8;
      3'd1:    s = 11'd16;
      3'd2:    s = 11'd33;
      3'd3:    s = 11'd66;
      3'd4:    s = 11'd132;
      3'd5:    s = 11'd264;
      3'd6:    s = 11'd528;
      default: s = 11'd1056;
    endcase
    return s;
  endfunction

  function automatic sample_t decode_sample(input logic [7:0] code);
    logic [MagW-1:0] mag;
    logic [14:0]     prod;
    prod = 15'(chord_step(code[7:5]) * code[4:1]);
    mag  = chord_base(code[7:5]) + prod;
    return code[0] ? -sample_t'({1'b0, mag}) : sample_t'({1'b0, mag});
  endfunction

  // codes outside 1..7 mute
  function automatic gain_t gain_left(input logic [3:0] pos);
    gain_t g;
    case (pos)
      4'd1:    g = 17'd65536;
      4'd2:    g = 17'd54394;
      4'd3:    g = 17'd43909;
      4'd4:    g = 17'd32768;
      4'd5:    g = 17'd21626;
      4'd6:    g = 17'd11141;
      default: g = 17'd0;
    endcase
    return g;
  endfunction

  function automatic gain_t gain_right(input logic [3:0] pos);
    gain_t g;
    case (pos)
      4'd2:    g = 17'd11141;
      4'd3:    g = 17'd21626;
      4'd4:    g = 17'd32768;
      4'd5:    g = 17'd43909;
      4'd6:    g = 17'd54394;
      4'd7:    g = 17'd65536;
      default: g = 17'd0;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/lspan_in_if.sv @@
interface lspan_in_if;
  import lspan_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] sample_code;

  modport source (output valid, output sample_code, input ready);
  modport sink   (input valid, input sample_code, output ready);
endinterface

@@ rtl/lspan_out_if.sv @@
interface lspan_out_if;
  import lspan_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  chan_t   channel_index;

  modport source (output valid, output left_sample, output right_sample,
                  output channel_index, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input channel_index, output ready);
endinterface

@@ rtl/lspan_cfg.sv @@
module lspan_cfg import lspan_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            swap_q, swap_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    pos_d  = pos_q;
    swap_d = swap_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegPositions: pos_d  = pwdata[PosW-1:0];
        RegSwap:      swap_d = pwdata[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      swap_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      swap_q <= swap_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegPositions: prdata = PdataW'(pos_q);
      RegSwap:      prdata = PdataW'(swap_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.stereo_positions = pos_q;
  assign cfg_o.swap_sides       = swap_q;

endmodule

@@ rtl/log_sample_to_linear_stereo_pan.sv @@
// path: an accepted input beat is registered in the input stage, then in the result stage
// throughput: one sample per cycle while res_o is not stalled; the decode and gain
//   lookup sit before the input register, the two gain multiplies before the result register
// reset: async active low, clears the stereo registers, the channel counter
//   and both stage valids; no clearing pass
module log_sample_to_linear_stereo_pan import lspan_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  lspan_in_if.sink          smp_i,
  lspan_out_if.source       res_o
);

  cfg_t cfg;

  lspan_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  // handshake
  logic in_acc, out_free, s1_adv;
  logic s1_valid_q, s1_valid_d;
  logic res_valid_q, res_valid_d;

  assign out_free    = !res_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign smp_i.ready = !s1_valid_q || out_free;
  assign in_acc      = smp_i.valid && smp_i.ready;

  // channel counter and gain lookup
  chan_t      chan_pos_q, chan_pos_d;
  code_t      chan_code;
  logic [3:0] eff_code;

  assign chan_pos_d = in_acc ? chan_pos_q + 1'b1 : chan_pos_q;
  assign chan_code  = cfg.stereo_positions[CodeW*chan_pos_q +: CodeW];
  // mirrored code 8 - 0 = 8 falls outside the table and mutes
  assign eff_code   = cfg.swap_sides ? 4'd8 - {1'b0, chan_code} : {1'b0, chan_code};

  // input stage
  sample_t value_q;
  gain_t   gl_q, gr_q;
  chan_t   chan_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      value_q <= decode_sample(smp_i.sample_code);
      gl_q    <= gain_left(eff_code);
      gr_q    <= gain_right(eff_code);
      chan_q  <= chan_pos_q;
    end
  end

  // gain products, floor by dropping the 16 fraction bits
  logic signed [GainW+SampleW:0] prod_l, prod_r;

  assign prod_l = $signed({1'b0, gl_q}) * value_q;
  assign prod_r = $signed({1'b0, gr_q}) * value_q;

  // result stage
  sample_t left_q, right_q;
  chan_t   chan_out_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q     <= prod_l[SampleW+15:16];
      right_q    <= prod_r[SampleW+15:16];
      chan_out_q <= chan_q;
    end
  end

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign res_valid_d = s1_adv ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      chan_pos_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      chan_pos_q  <= chan_pos_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.left_sample   = left_q;
  assign res_o.right_sample  = right_q;
  assign res_o.channel_index = chan_out_q;

  // channel counter steps by one per accepted beat
  a_chan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> chan_pos_q == chan_t'($past(chan_pos_q) + 1'b1))
    else $error("channel counter did not advance");

  // a held input stage that cannot drain must block new beats
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |-> !smp_i.ready)
    else $error("input stage overrun");

  // live gain pairs sum to unity within one lsb, or both mute
  a_gain_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ((18'(gl_q) + 18'(gr_q)) == 18'd65536 ||
                    (18'(gl_q) + 18'(gr_q)) == 18'd65535 ||
                    (gl_q == '0 && gr_q == '0)))
    else $error("gain pair inconsistent");

  // a muted channel gives silent outputs
  a_mute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && gl_q == '0 && gr_q == '0 |=> left_q == '0 && right_q == '0)
    else $error("muted channel not silent");

endmodule

@@ tb/lspan_checker.sv @@
`timescale 1ns / 1ps

module lspan_checker import lspan_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  lspan_in_if               smp,
  lspan_out_if              res,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct {
    sample_t left;
    sample_t right;
    chan_t   chan;
  } pan_result_t;

  // 16.16 gains indexed by stereo code, 0 stands for mute
  int unsigned left_gain_tab[8]  = '{0, 65536, 54394, 43909, 32768, 21626, 11141, 0};
  int unsigned right_gain_tab[8] = '{0, 0, 11141, 21626, 32768, 43909, 54394, 65536};

  logic [PosW-1:0] stereo_codes;
  logic            mirror_sides;
  chan_t           next_chan;
  pan_result_t     pan_expected[$];
  pan_result_t     want;
  logic [3:0]      image;
  int unsigned     left_gain;
  int unsigned     right_gain;
  int              level;

  // chord/point log code to signed linear level
  function automatic int linear_level(input logic [7:0] code);
    int chord;
    int point;
    int mag;
    chord = int'(code[7:5]);
    point = int'(code[4:1]);
    mag   = ((1 << chord) - 1) * 132 + (((1 << chord) * 132) / 16) * point;
    return code[0] ? -mag : mag;
  endfunction

  // arithmetic shift of the signed product floors toward minus infinity
  function automatic sample_t apply_gain(input int unsigned gain, input int lvl);
    longint prod;
    prod = longint'(gain) * longint'(lvl);
    return sample_t'(prod >>> 16);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_codes = '0;
      mirror_sides = 1'b0;
      next_chan    = '0;
      pan_expected.delete();
      fail_count   = 0;
      pending      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PaddrW-1:2])
          RegPositions: stereo_codes = pwdata[PosW-1:0];
          RegSwap:      mirror_sides = pwdata[0];
          default:      ;
        endcase
      end

      // compare before predicting so a same-cycle input cannot hide a stray beat
      if (res.valid && res.ready) begin
        if (pan_expected.size() == 0) begin
          $error("result beat with nothing pending: left %0d right %0d channel %0d",
                 res.left_sample, res.right_sample, res.channel_index);
          fail_count++;
        end else begin
          want = pan_expected.pop_front();
          if (res.left_sample !== want.left) begin
            $error("left_sample: expected %0d, got %0d", want.left, res.left_sample);
            fail_count++;
          end
          if (res.right_sample !== want.right) begin
            $error("right_sample: expected %0d, got %0d", want.right, res.right_sample);
            fail_count++;
          end
          if (res.channel_index !== want.chan) begin
            $error("channel_index: expected %0d, got %0d", want.chan, res.channel_index);
            fail_count++;
          end
        end
      end

      if (smp.valid && smp.ready) begin
        image = 4'(stereo_codes[3*next_chan +: 3]);
        if (mirror_sides) image = 4'd8 - image;
        left_gain  = (image >= 4'd1 && image <= 4'd7) ? left_gain_tab[image[2:0]] : 0;
        right_gain = (image >= 4'd1 && image <= 4'd7) ? right_gain_tab[image[2:0]] : 0;
        level      = linear_level(smp.sample_code);
        want.left  = apply_gain(left_gain, level);
        want.right = apply_gain(right_gain, level);
        want.chan  = next_chan;
        pan_expected.push_back(want);
        next_chan  = next_chan + 1'b1;
      end

      pending = pan_expected.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lspan_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 150;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  logic              steady_flow;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       stall_cycles = 0;

  lspan_in_if  smp_if ();
  lspan_out_if res_if ();

  log_sample_to_linear_stereo_pan dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .smp_i   (smp_if),
    .res_o   (res_if)
  );

  lspan_checker pan_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .smp        (smp_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    res_if.ready = steady_flow || ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic reg_write(input logic idx, input logic [PdataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // valid stays high after the beat so back-to-back samples keep it up
  task automatic send_sample(input logic [7:0] code);
    while (!steady_flow && $urandom_range(99) < 22) begin
      smp_if.valid = 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid       = 1'b1;
    smp_if.sample_code = code;
    do @(posedge clk_i); while (!smp_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    smp_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  logic [7:0]      edge_codes[16];
  logic [PosW-1:0] pos_word;

  initial begin
    edge_codes = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'hE0, 8'hE1, 8'h1E, 8'h1F,
                   8'h02, 8'h03, 8'h20, 8'h21, 8'hC0, 8'h7F, 8'h80, 8'h5A};
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    steady_flow        = 1'b0;
    smp_if.valid       = 1'b0;
    smp_if.sample_code = '0;
    res_if.ready       = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // channel c carries stereo code c; after the swap each channel gets a full-scale sample
    reg_write(RegPositions, {8'hA5, 24'o76543210});
    reg_write(RegSwap, 32'hFFFF_FFFE);
    foreach (edge_codes[i]) send_sample(edge_codes[i]);
    drain();
    reg_write(RegSwap, 32'h0000_0001);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 8'hFF : 8'hFE);
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       pos_word = '1;
        1:       pos_word = '0;
        2:       pos_word = 24'o44444444;
        default: pos_word = PosW'($urandom());
      endcase
      reg_write(RegPositions, {8'($urandom()), pos_word});
      reg_write(RegSwap, (p == 0) ? 32'h1 : (p == 1) ? 32'h0 : $urandom());
      steady_flow = (p == 4);
      for (int i = 0; i < PhaseItems; i++) send_sample(8'($urandom_range(0, 255)));
      drain();
    end
    steady_flow = 1'b0;

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ log_sample_to_linear_stereo_pan.f @@
rtl/lspan_pkg.sv
rtl/lspan_in_if.sv
rtl/lspan_out_if.sv
rtl/lspan_cfg.sv
rtl/log_sample_to_linear_stereo_pan.sv
tb/lspan_checker.sv
tb/tb.sv
